/* rtl/kbl_pkg.sv */
// shared types and constants of the keyed token bucket limiter
`default_nettype none
package kbl_pkg;

  localparam int NUM_BUCKETS = 64;
  localparam int IDX_W       = $clog2(NUM_BUCKETS);
  localparam int TOK_W       = 48;
  localparam int RATE_W      = 32;
  localparam int TICK_W      = 32;
  localparam int CNT_W       = 48;
  localparam int ACT_W       = 7;
  localparam int IN_DATA_W   = 168;
  localparam int OUT_DATA_W  = 280;

  localparam logic [RATE_W-1:0] DEFAULT_RATE_RST = 32'd655;
  localparam logic [TOK_W-1:0]  DEFAULT_CAP_RST  = 48'd6553600;

  localparam logic [0:0] REG_DEFAULT_RATE = 1'b0;
  localparam logic [0:0] REG_DEFAULT_CAP  = 1'b1;

  localparam logic [2:0] OPC_CONSUME   = 3'd0;
  localparam logic [2:0] OPC_CHECK     = 3'd1;
  localparam logic [2:0] OPC_RESET_ONE = 3'd2;
  localparam logic [2:0] OPC_RESET_ALL = 3'd3;
  localparam logic [2:0] OPC_SET_RATE  = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE, OP_CONSUME, OP_CHECK, OP_RESET_ONE, OP_RESET_ALL, OP_SET_RATE
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [IDX_W-1:0]    idx;
    logic [TOK_W-1:0]    amount;
    logic [TICK_W-1:0]   now;
    logic [RATE_W-1:0]   rate_value;
    logic [TOK_W-1:0]    cap_value;
    logic                rate_given;
    logic                cap_given;
  } item_t;

  typedef struct packed {
    logic [TOK_W-1:0]  tokens;
    logic [RATE_W-1:0] rate;
    logic [TOK_W-1:0]  cap;
    logic [TICK_W-1:0] last;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/kbl_front.sv */
// front end: decodes requests and holds them in a two-entry queue
`default_nettype none
module kbl_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [kbl_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic [2:0]                     s_tuser,
  output logic                                q_valid,
  output kbl_pkg::item_t                      q_item,
  input  wire logic                           q_pop
);

  kbl_pkg::item_t store [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  kbl_pkg::item_t dec;
  logic           push;

  always_comb begin
    dec.idx        = s_tdata[5:0];
    dec.amount     = s_tdata[53:6];
    dec.now        = s_tdata[85:54];
    dec.rate_value = s_tdata[117:86];
    dec.cap_value  = s_tdata[165:118];
    dec.rate_given = s_tdata[166];
    dec.cap_given  = s_tdata[167];
    unique case (s_tuser)
      kbl_pkg::OPC_CONSUME:   dec.kind = kbl_pkg::OP_CONSUME;
      kbl_pkg::OPC_CHECK:     dec.kind = kbl_pkg::OP_CHECK;
      kbl_pkg::OPC_RESET_ONE: dec.kind = kbl_pkg::OP_RESET_ONE;
      kbl_pkg::OPC_RESET_ALL: dec.kind = kbl_pkg::OP_RESET_ALL;
      kbl_pkg::OPC_SET_RATE:  dec.kind = kbl_pkg::OP_SET_RATE;
      default:                dec.kind = kbl_pkg::OP_NONE;
    endcase
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/kbl_back.sv */
// back end: bucket table read-modify-write, counters and result register
`default_nettype none
module kbl_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [kbl_pkg::RATE_W-1:0]       default_rate,
  input  wire logic [kbl_pkg::TOK_W-1:0]        default_cap,
  input  wire logic                             q_valid,
  input  wire kbl_pkg::item_t                   q_item,
  output logic                                  q_pop,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [kbl_pkg::OUT_DATA_W-1:0]        m_tdata
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_READ     = 7'b0000010,
    S_MUL      = 7'b0000100,
    S_REFILL   = 7'b0001000,
    S_EXEC     = 7'b0010000,
    S_SWEEP_RD = 7'b0100000,
    S_SWEEP_WR = 7'b1000000
  } state_t;

  state_t                          state;
  kbl_pkg::item_t                  item;
  kbl_pkg::entry_t                 mem [kbl_pkg::NUM_BUCKETS];
  kbl_pkg::entry_t                 rd_data;
  logic                            rd_en;
  logic [kbl_pkg::IDX_W-1:0]       rd_addr;
  logic                            wr_en;
  logic [kbl_pkg::IDX_W-1:0]       wr_addr;
  kbl_pkg::entry_t                 wr_data;
  logic [kbl_pkg::NUM_BUCKETS-1:0] bucket_valid;
  logic                            was_valid;
  kbl_pkg::entry_t                 ent;
  logic [kbl_pkg::TICK_W-1:0]      elapsed;
  logic [63:0]                     prod;
  logic [kbl_pkg::TOK_W-1:0]       tok_ref;
  logic [kbl_pkg::IDX_W-1:0]       sweep_cnt;
  logic [kbl_pkg::CNT_W-1:0]       total_count;
  logic [kbl_pkg::CNT_W-1:0]       allowed_count;
  logic [kbl_pkg::CNT_W-1:0]       rejected_count;
  logic [kbl_pkg::ACT_W-1:0]       created_count;

  // exec stage results
  kbl_pkg::entry_t                 ex_ent;
  logic                            ex_write;
  logic                            ex_allowed;
  logic                            ex_exists;
  logic                            ex_create;
  logic                            ex_count;
  logic [64:0]                     sum;
  logic [kbl_pkg::TOK_W-1:0]       refilled;

  localparam logic [kbl_pkg::CNT_W-1:0] CNT_MAX = '1;
  localparam logic [kbl_pkg::ACT_W-1:0] ACT_MAX = '1;

  assign q_pop = (state == S_IDLE) && q_valid && !m_tvalid;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = q_item.idx;
    if (q_pop) begin
      rd_en = 1'b1;
    end else if (state == S_SWEEP_RD) begin
      rd_en   = 1'b1;
      rd_addr = sweep_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // lazy refill with saturation at the capacity
  always_comb begin
    sum      = {17'd0, ent.tokens} + {1'b0, prod};
    refilled = (prod >= {16'd0, ent.cap} || sum >= {17'd0, ent.cap}) ? ent.cap
                                                                      : sum[47:0];
  end

  always_comb begin
    ex_ent     = ent;
    ex_write   = 1'b0;
    ex_allowed = 1'b0;
    ex_exists  = was_valid;
    ex_create  = 1'b0;
    ex_count   = 1'b0;
    case (item.kind) inside
      kbl_pkg::OP_CONSUME, kbl_pkg::OP_CHECK: begin
        ex_ent.tokens = tok_ref;
        ex_ent.last   = item.now;
        ex_allowed    = (tok_ref >= item.amount);
        if (item.kind == kbl_pkg::OP_CONSUME) begin
          ex_count = 1'b1;
          if (ex_allowed) ex_ent.tokens = tok_ref - item.amount;
        end
        ex_write  = 1'b1;
        ex_exists = 1'b1;
        ex_create = !was_valid;
      end
      kbl_pkg::OP_RESET_ONE, kbl_pkg::OP_RESET_ALL: begin
        ex_ent.tokens = ent.cap;
        ex_ent.last   = item.now;
        ex_write      = was_valid && (item.kind == kbl_pkg::OP_RESET_ONE);
      end
      kbl_pkg::OP_SET_RATE: begin
        if (item.rate_given) ex_ent.rate = item.rate_value;
        if (item.cap_given) begin
          ex_ent.cap = item.cap_value;
          if (ent.tokens > item.cap_value) ex_ent.tokens = item.cap_value;
        end
        ex_write  = 1'b1;
        ex_exists = 1'b1;
        ex_create = !was_valid;
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = item.idx;
    wr_data = ex_ent;
    if (state == S_EXEC) begin
      wr_en = ex_write;
    end else if (state == S_SWEEP_WR) begin
      wr_addr        = sweep_cnt;
      wr_data        = rd_data;
      wr_data.tokens = rd_data.cap;
      wr_data.last   = item.now;
      wr_en          = bucket_valid[sweep_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) item <= q_item;
    if (state == S_READ) begin
      was_valid <= bucket_valid[item.idx];
      if (bucket_valid[item.idx]) begin
        ent     <= rd_data;
        elapsed <= item.now - rd_data.last;
      end else begin
        ent.tokens <= default_cap;
        ent.rate   <= default_rate;
        ent.cap    <= default_cap;
        ent.last   <= item.now;
        elapsed    <= '0;
      end
    end
    if (state == S_MUL) prod <= {32'd0, elapsed} * {32'd0, ent.rate};
    if (state == S_REFILL) tok_ref <= refilled;
    if (state == S_EXEC) begin
      m_tdata[0]       <= ex_allowed;
      m_tdata[48:1]    <= ex_exists ? ex_ent.tokens : '0;
      m_tdata[96:49]   <= ex_exists ? ex_ent.cap : '0;
      m_tdata[128:97]  <= ex_exists ? ex_ent.rate : '0;
      m_tdata[176:129] <= (ex_count && total_count != CNT_MAX) ?
                          total_count + 1'b1 : total_count;
      m_tdata[224:177] <= (ex_count && ex_allowed && allowed_count != CNT_MAX) ?
                          allowed_count + 1'b1 : allowed_count;
      m_tdata[272:225] <= (ex_count && !ex_allowed && rejected_count != CNT_MAX) ?
                          rejected_count + 1'b1 : rejected_count;
      m_tdata[279:273] <= (ex_create && created_count != ACT_MAX) ?
                          created_count + 1'b1 : created_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      bucket_valid   <= '0;
      sweep_cnt      <= '0;
      total_count    <= '0;
      allowed_count  <= '0;
      rejected_count <= '0;
      created_count  <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE:   if (q_pop) state <= S_READ;
        S_READ:   state <= S_MUL;
        S_MUL:    state <= S_REFILL;
        S_REFILL: state <= S_EXEC;
        S_EXEC: begin
          if (ex_create) begin
            bucket_valid[item.idx] <= 1'b1;
            if (created_count != ACT_MAX) created_count <= created_count + 1'b1;
          end
          if (ex_count) begin
            if (total_count != CNT_MAX) total_count <= total_count + 1'b1;
            if (ex_allowed) begin
              if (allowed_count != CNT_MAX) allowed_count <= allowed_count + 1'b1;
            end else if (rejected_count != CNT_MAX) begin
              rejected_count <= rejected_count + 1'b1;
            end
          end
          if (item.kind == kbl_pkg::OP_RESET_ALL) begin
            state <= S_SWEEP_RD;
          end else begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_SWEEP_RD: state <= S_SWEEP_WR;
        S_SWEEP_WR: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == kbl_pkg::IDX_W'(kbl_pkg::NUM_BUCKETS - 1)) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end else begin
            state <= S_SWEEP_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_created_monotonic: assert property (@(posedge clk) disable iff (rst)
    created_count >= $past(created_count))
    else $error("created count went down");

  a_sweep_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (sweep_cnt == '0))
    else $error("sweep counter not back at zero");

  a_counts_consistent: assert property (@(posedge clk) disable iff (rst)
    (total_count != CNT_MAX) |-> (total_count == allowed_count + rejected_count))
    else $error("request counters disagree");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_EXEC || state == S_SWEEP_WR))
    else $error("table write outside an update step");

endmodule
`default_nettype wire

/* rtl/keyed_token_bucket_limiter.sv */
// top level of the keyed token bucket limiter
`default_nettype none
// Table of 64 token buckets addressed by bucket number, created full on first
// touch with the default rate and capacity, refilled lazily from the tick
// stamp. Each request goes through the back end alone (table read, refill
// multiply, saturating add, update and write-back) and gives one result;
// reset all then sweeps the table one entry at a time, reading and writing back.
// A two-entry queue takes requests while the back end works or a result waits.
// The default registers are written through cfg_we/cfg_index/cfg_data.
module keyed_token_bucket_limiter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [0:0]                      cfg_index,
  input  wire logic [47:0]                     cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // bucket_index, amount, now_tick, rate_value, capacity_value,
  // rate_given, capacity_given
  input  wire logic [kbl_pkg::IN_DATA_W-1:0]   s_tdata,
  // operation
  input  wire logic [2:0]                      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // allowed, tokens_now, capacity_now, rate_now, total_requests,
  // allowed_requests, rejected_requests, active_buckets
  output logic [kbl_pkg::OUT_DATA_W-1:0]       m_tdata
);

  logic [kbl_pkg::RATE_W-1:0] default_rate;
  logic [kbl_pkg::TOK_W-1:0]  default_cap;
  logic                       q_valid;
  logic                       q_pop;
  kbl_pkg::item_t             q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_rate <= kbl_pkg::DEFAULT_RATE_RST;
      default_cap  <= kbl_pkg::DEFAULT_CAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kbl_pkg::REG_DEFAULT_RATE: default_rate <= cfg_data[31:0];
        kbl_pkg::REG_DEFAULT_CAP:  default_cap  <= cfg_data;
        default: ;
      endcase
    end
  end

  kbl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  kbl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .default_rate (default_rate),
    .default_cap  (default_cap),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule
`default_nettype wire

/* tb/tb_keyed_token_bucket_limiter.sv */
// self-checking testbench for the keyed token bucket limiter
`default_nettype none
module tb_keyed_token_bucket_limiter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int        CYCLE_LIMIT = 1000000;
  localparam int        SETTLE      = 200;
  localparam logic [2:0] OPC_SPARE_LO = 3'd5;
  localparam logic [2:0] OPC_SPARE_MID = 3'd6;
  localparam logic [2:0] OPC_SPARE_HI = 3'd7;
  localparam logic [kbl_pkg::TOK_W-1:0] MAX48 = '1;

  // s_tdata layout, lowest field last in the declaration
  typedef struct packed {
    logic                       capacity_given;
    logic                       rate_given;
    logic [kbl_pkg::TOK_W-1:0]  capacity_value;
    logic [kbl_pkg::RATE_W-1:0] rate_value;
    logic [kbl_pkg::TICK_W-1:0] now_tick;
    logic [kbl_pkg::TOK_W-1:0]  amount;
    logic [kbl_pkg::IDX_W-1:0]  bucket_index;
  } request_t;

  typedef struct packed {
    logic [kbl_pkg::ACT_W-1:0]  active_buckets;
    logic [kbl_pkg::CNT_W-1:0]  rejected_requests;
    logic [kbl_pkg::CNT_W-1:0]  allowed_requests;
    logic [kbl_pkg::CNT_W-1:0]  total_requests;
    logic [kbl_pkg::RATE_W-1:0] rate_now;
    logic [kbl_pkg::TOK_W-1:0]  capacity_now;
    logic [kbl_pkg::TOK_W-1:0]  tokens_now;
    logic                       allowed;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [47:0] cfg_data;
  logic s_tvalid;
  logic s_tready;
  // bucket_index, amount, now_tick, rate_value, capacity_value, rate_given, capacity_given
  logic [kbl_pkg::IN_DATA_W-1:0] s_tdata;
  logic [2:0] s_tuser;            // operation
  logic m_tvalid;
  logic m_tready;
  // allowed, tokens_now, capacity_now, rate_now, total_requests,
  // allowed_requests, rejected_requests, active_buckets
  logic [kbl_pkg::OUT_DATA_W-1:0] m_tdata;

  keyed_token_bucket_limiter dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  // bucket table shadow
  logic                       bkt_valid [kbl_pkg::NUM_BUCKETS];
  logic [kbl_pkg::TOK_W-1:0]  bkt_tokens [kbl_pkg::NUM_BUCKETS];
  logic [kbl_pkg::RATE_W-1:0] bkt_rate [kbl_pkg::NUM_BUCKETS];
  logic [kbl_pkg::TOK_W-1:0]  bkt_cap [kbl_pkg::NUM_BUCKETS];
  logic [kbl_pkg::TICK_W-1:0] bkt_last [kbl_pkg::NUM_BUCKETS];
  logic [kbl_pkg::CNT_W-1:0]  n_total, n_granted, n_refused;
  logic [kbl_pkg::ACT_W-1:0]  n_created;
  logic [kbl_pkg::RATE_W-1:0] dflt_rate;
  logic [kbl_pkg::TOK_W-1:0]  dflt_cap;

  verdict_t   verdicts_due[$];
  int         errors = 0;
  int         n_checked = 0;
  int         op_seen [8];
  int         cycles = 0;
  bit         gaps_on = 1'b1;
  int         hold_off = 0;
  logic [kbl_pkg::TICK_W-1:0] tick_now = 32'd1000;

  function automatic logic [kbl_pkg::CNT_W-1:0] sat_inc(logic [kbl_pkg::CNT_W-1:0] v);
    return (v == MAX48) ? v : v + 1'b1;
  endfunction

  function automatic void create_bucket(int b, logic [kbl_pkg::TICK_W-1:0] now);
    if (!bkt_valid[b]) begin
      bkt_valid[b] = 1'b1;
      bkt_rate[b] = dflt_rate;
      bkt_cap[b] = dflt_cap;
      bkt_tokens[b] = dflt_cap;
      bkt_last[b] = now;
      if (n_created != 7'd127) n_created++;
    end
  endfunction

  function automatic void top_up(int b, logic [kbl_pkg::TICK_W-1:0] now);
    logic [kbl_pkg::TICK_W-1:0] elapsed;
    logic [63:0] gain;
    logic [64:0] sum;
    elapsed = now - bkt_last[b];
    if (elapsed == '0) return;
    gain = 64'(elapsed) * 64'(bkt_rate[b]);
    sum = 65'(bkt_tokens[b]) + 65'(gain);
    if (gain >= 64'(bkt_cap[b]) || sum >= 65'(bkt_cap[b])) bkt_tokens[b] = bkt_cap[b];
    else bkt_tokens[b] = sum[kbl_pkg::TOK_W-1:0];
    bkt_last[b] = now;
  endfunction

  function automatic verdict_t bucket_outcome(logic [2:0] op, request_t r);
    verdict_t v;
    int b;
    v = '0;
    b = int'(r.bucket_index);
    case (op)
      kbl_pkg::OPC_CONSUME: begin
        n_total = sat_inc(n_total);
        create_bucket(b, r.now_tick);
        top_up(b, r.now_tick);
        if (bkt_tokens[b] >= r.amount) begin
          bkt_tokens[b] -= r.amount;
          v.allowed = 1'b1;
          n_granted = sat_inc(n_granted);
        end else begin
          n_refused = sat_inc(n_refused);
        end
      end
      kbl_pkg::OPC_CHECK: begin
        create_bucket(b, r.now_tick);
        top_up(b, r.now_tick);
        v.allowed = bkt_tokens[b] >= r.amount;
      end
      kbl_pkg::OPC_RESET_ONE: begin
        if (bkt_valid[b]) begin
          bkt_tokens[b] = bkt_cap[b];
          bkt_last[b] = r.now_tick;
        end
      end
      kbl_pkg::OPC_RESET_ALL: begin
        for (int i = 0; i < kbl_pkg::NUM_BUCKETS; i++) begin
          if (bkt_valid[i]) begin
            bkt_tokens[i] = bkt_cap[i];
            bkt_last[i] = r.now_tick;
          end
        end
      end
      kbl_pkg::OPC_SET_RATE: begin
        create_bucket(b, r.now_tick);
        if (r.rate_given) bkt_rate[b] = r.rate_value;
        if (r.capacity_given) begin
          bkt_cap[b] = r.capacity_value;
          if (bkt_tokens[b] > r.capacity_value) bkt_tokens[b] = r.capacity_value;
        end
      end
      default: ;
    endcase
    if (bkt_valid[b]) begin
      v.tokens_now = bkt_tokens[b];
      v.capacity_now = bkt_cap[b];
      v.rate_now = bkt_rate[b];
    end
    v.total_requests = n_total;
    v.allowed_requests = n_granted;
    v.rejected_requests = n_refused;
    v.active_buckets = n_created;
    return v;
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 60)
        $display("%0t ns mismatch %s: expected %0h actual %0h", $realtime, name, want, got);
    end
  endtask

  // result side: check each transfer and draw the next stall
  always @(posedge clk) begin
    verdict_t got, want;
    int stall;
    if (rst) begin
      m_tready <= 1'b0;
      stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        n_checked++;
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t ns mismatch unexpected result: expected none actual %0h",
                   $realtime, m_tdata);
        end else begin
          want = verdicts_due.pop_front();
          compare_field("allowed", 64'(want.allowed), 64'(got.allowed));
          compare_field("tokens_now", 64'(want.tokens_now), 64'(got.tokens_now));
          compare_field("capacity_now", 64'(want.capacity_now), 64'(got.capacity_now));
          compare_field("rate_now", 64'(want.rate_now), 64'(got.rate_now));
          compare_field("total_requests", 64'(want.total_requests),
                        64'(got.total_requests));
          compare_field("allowed_requests", 64'(want.allowed_requests),
                        64'(got.allowed_requests));
          compare_field("rejected_requests", 64'(want.rejected_requests),
                        64'(got.rejected_requests));
          compare_field("active_buckets", 64'(want.active_buckets),
                        64'(got.active_buckets));
        end
        stall = gaps_on ? $urandom_range(0, 16) : 0;
      end
      if (hold_off > 0) begin
        hold_off--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, verdicts_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one transfer on the request side; valid stays high if the next item follows at once
  task automatic send_request(logic [2:0] op, request_t r);
    int gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= r;
    do @(posedge clk); while (!s_tready);
    verdicts_due.push_back(bucket_outcome(op, r));
    op_seen[op]++;
  endtask

  task automatic send_op(logic [2:0] op, int b, logic [47:0] amount, logic [31:0] now);
    request_t r;
    r = '0;
    r.bucket_index = kbl_pkg::IDX_W'(b);
    r.amount = amount;
    r.now_tick = now;
    r.rate_value = $urandom;
    r.capacity_value = rand48();
    send_request(op, r);
  endtask

  task automatic send_set_rate(int b, logic [31:0] now, logic rg, logic [31:0] rv,
                               logic cg, logic [47:0] cv);
    request_t r;
    r = '0;
    r.bucket_index = kbl_pkg::IDX_W'(b);
    r.amount = rand48();
    r.now_tick = now;
    r.rate_given = rg;
    r.rate_value = rv;
    r.capacity_given = cg;
    r.capacity_value = cv;
    send_request(kbl_pkg::OPC_SET_RATE, r);
  endtask

  // drain every outstanding result, then let a reset-all sweep finish
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_default(logic [0:0] idx, logic [47:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == kbl_pkg::REG_DEFAULT_RATE) dflt_rate = value[kbl_pkg::RATE_W-1:0];
    else dflt_cap = value;
  endtask

  task automatic test_consume_and_check();
    send_op(kbl_pkg::OPC_CONSUME, 0, 48'd0, 32'd100);
    send_op(kbl_pkg::OPC_CONSUME, 0, dflt_cap, 32'd100);
    send_op(kbl_pkg::OPC_CONSUME, 0, 48'd1, 32'd100);      // no time passed, still empty
    send_op(kbl_pkg::OPC_CHECK, 0, 48'd6550, 32'd110);
    send_op(kbl_pkg::OPC_CHECK, 0, 48'd6551, 32'd110);
    send_op(kbl_pkg::OPC_CONSUME, 63, MAX48, 32'hFFFF_FFF0);
    send_op(kbl_pkg::OPC_CHECK, 63, MAX48, 32'd5);         // tick wraps
  endtask

  task automatic test_resets();
    send_op(kbl_pkg::OPC_RESET_ONE, 5, 48'd0, 32'd200);    // bucket never created
    send_op(kbl_pkg::OPC_CONSUME, 0, 48'd1000, 32'd200);
    send_op(kbl_pkg::OPC_RESET_ONE, 0, 48'd0, 32'd201);
    send_op(kbl_pkg::OPC_CONSUME, 63, 48'd12345, 32'd202);
    send_op(kbl_pkg::OPC_RESET_ALL, 17, 48'd0, 32'd203);
    send_op(kbl_pkg::OPC_CHECK, 63, 48'd0, 32'd203);
  endtask

  task automatic test_set_rate();
    send_set_rate(63, 32'd300, 1'b0, 32'd0, 1'b0, 48'd0);
    send_set_rate(63, 32'd301, 1'b1, 32'hFFFF_FFFF, 1'b0, 48'd0);
    send_set_rate(63, 32'd302, 1'b0, 32'd0, 1'b1, 48'd70000);        // clamps tokens
    send_set_rate(9, 32'd303, 1'b1, 32'd0, 1'b1, MAX48);             // creates the bucket
    send_op(kbl_pkg::OPC_CHECK, 63, 48'd70000, 32'hFFFF_FFFF);       // huge refill saturates
    send_op(kbl_pkg::OPC_CONSUME, 9, MAX48, 32'd999);
  endtask

  task automatic test_spare_codes();
    for (int op = OPC_SPARE_LO; op <= OPC_SPARE_HI; op++) begin
      send_op(op[2:0], 0, rand48(), $urandom);
      send_op(op[2:0], 40, rand48(), $urandom);
    end
  endtask

  task automatic send_random(int lo, int hi);
    request_t r;
    logic [2:0] op;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) op = kbl_pkg::OPC_CONSUME;
    else if (pick < 70) op = kbl_pkg::OPC_CHECK;
    else if (pick < 82) op = kbl_pkg::OPC_SET_RATE;
    else if (pick < 91) op = kbl_pkg::OPC_RESET_ONE;
    else if (pick < 94) op = kbl_pkg::OPC_RESET_ALL;
    else op = 3'($urandom_range(OPC_SPARE_LO, OPC_SPARE_HI));
    if ($urandom_range(0, 19) == 0) tick_now = $urandom;
    else tick_now = tick_now + 32'($urandom_range(0, 40));
    r.bucket_index = kbl_pkg::IDX_W'($urandom_range(lo, hi));
    r.now_tick = tick_now;
    r.amount = ($urandom_range(0, 9) == 0) ? rand48() : 48'($urandom_range(0, 1 << 24));
    r.rate_value = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1 << 20);
    r.capacity_value = ($urandom_range(0, 4) == 0) ? rand48() : 48'($urandom_range(0, 1 << 28));
    r.rate_given = 1'($urandom_range(0, 1));
    r.capacity_given = 1'($urandom_range(0, 1));
    send_request(op, r);
  endtask

  task automatic test_random_phase(int count, int lo, int hi);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      send_random(lo, hi);
    end
    gaps_on = 1'b1;
  endtask

  // receiver holds off long enough for the input side to back up
  task automatic test_backpressure();
    wait_idle();
    hold_off = 400;
    gaps_on = 1'b0;
    for (int i = 0; i < 30; i++) send_random(0, kbl_pkg::NUM_BUCKETS - 1);
    gaps_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    dflt_rate = kbl_pkg::DEFAULT_RATE_RST;
    dflt_cap = kbl_pkg::DEFAULT_CAP_RST;
    n_total = '0;
    n_granted = '0;
    n_refused = '0;
    n_created = '0;
    for (int i = 0; i < kbl_pkg::NUM_BUCKETS; i++) begin
      bkt_valid[i] = 1'b0;
      bkt_tokens[i] = '0;
      bkt_rate[i] = '0;
      bkt_cap[i] = '0;
      bkt_last[i] = '0;
    end
    for (int i = 0; i < 8; i++) op_seen[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_consume_and_check();
    test_resets();
    test_set_rate();
    test_spare_codes();
    // new buckets in each window pick up that window's defaults
    test_random_phase(250, 1, 15);
    write_default(kbl_pkg::REG_DEFAULT_RATE, 48'hFFFF_FFFF);
    write_default(kbl_pkg::REG_DEFAULT_CAP, MAX48);
    test_random_phase(250, 16, 31);
    write_default(kbl_pkg::REG_DEFAULT_RATE, 48'd0);
    write_default(kbl_pkg::REG_DEFAULT_CAP, 48'd0);
    test_random_phase(250, 32, 47);
    write_default(kbl_pkg::REG_DEFAULT_RATE, {16'd0, $urandom});
    write_default(kbl_pkg::REG_DEFAULT_CAP, rand48());
    test_random_phase(250, 48, 62);
    test_backpressure();
    test_random_phase(550, 0, kbl_pkg::NUM_BUCKETS - 1);

    wait_idle();
    $display("covered %0d consume, %0d check, %0d reset one, %0d reset all, %0d set rate,",
             op_seen[kbl_pkg::OPC_CONSUME], op_seen[kbl_pkg::OPC_CHECK],
             op_seen[kbl_pkg::OPC_RESET_ONE], op_seen[kbl_pkg::OPC_RESET_ALL],
             op_seen[kbl_pkg::OPC_SET_RATE]);
    $display("%0d spare codes; %0d results checked, %0d buckets created",
             op_seen[OPC_SPARE_LO] + op_seen[OPC_SPARE_MID] + op_seen[OPC_SPARE_HI],
             n_checked, n_created);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/kbl_pkg.sv
rtl/kbl_front.sv
rtl/kbl_back.sv
rtl/keyed_token_bucket_limiter.sv
tb/tb_keyed_token_bucket_limiter.sv
